### rtl/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg
// Shared widths, codes and fixed-point helpers for the separable polynomial
// evaluator.
// ----------------------------------------------------------------------------
package spe_pkg;

    // default sizes handed to the top level
    localparam int DEF_MAX_DIMS    = 4;
    localparam int DEF_MAX_DEGREE  = 4;
    localparam int DEF_MAX_OUTPUTS = 4;

    // fixed field widths
    localparam int COORD_FIELDS = 4;
    localparam int COORD_IDX_W  = 2;
    localparam int DATA_W       = 16;
    localparam int SEL_W        = 2;
    localparam int CFG_W        = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CHAN_W       = 2;
    localparam int VALUE_W      = 21;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int SUM_W        = VALUE_W + 1;

    // request type codes
    localparam logic REQ_EVAL  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS = 2'd2;

    // result range
    localparam logic signed [SUM_W-1:0] ACC_MAX = 22'sd1048575;
    localparam logic signed [SUM_W-1:0] ACC_MIN = -22'sd1048576;

    // zero reads as one, values above the limit read as the limit
    function automatic logic [CFG_W-1:0] limit_cfg(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    // power product floored to Q2.14 and clamped to 16 bits
    function automatic logic signed [DATA_W-1:0] pow_sat(
        input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        logic signed [DATA_W-1:0] r;
        s = p >>> 14;
        if (s > 32'sd32767)
            r = 16'sh7fff;
        else if (s < -32'sd32768)
            r = 16'sh8000;
        else
            r = s[DATA_W-1:0];
        return r;
    endfunction

    // accumulate a floored Q.14 term with saturation to the result range
    function automatic logic signed [VALUE_W-1:0] acc_add(
        input logic signed [VALUE_W-1:0] acc,
        input logic signed [PROD_W-1:0]  p);
        logic signed [PROD_W-1:0] t;
        logic signed [SUM_W-1:0]  s;
        logic signed [VALUE_W-1:0] r;
        t = p >>> 15;
        s = SUM_W'(acc) + t[SUM_W-1:0];
        if (s > ACC_MAX)
            r = ACC_MAX[VALUE_W-1:0];
        else if (s < ACC_MIN)
            r = ACC_MIN[VALUE_W-1:0];
        else
            r = s[VALUE_W-1:0];
        return r;
    endfunction

endpackage

### rtl/spe_req_if.sv
// ----------------------------------------------------------------------------
// spe_req_if
// Request channel: point evaluation or coefficient write.
// ----------------------------------------------------------------------------
interface spe_req_if;
    import spe_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [DATA_W-1:0] coord_0;
    logic signed [DATA_W-1:0] coord_1;
    logic signed [DATA_W-1:0] coord_2;
    logic signed [DATA_W-1:0] coord_3;
    logic [SEL_W-1:0]         coef_output;
    logic [SEL_W-1:0]         coef_power;
    logic [SEL_W-1:0]         coef_dim;
    logic signed [DATA_W-1:0] coef_value;

    modport source (output valid, req_type, coord_0, coord_1, coord_2, coord_3,
                    coef_output, coef_power, coef_dim, coef_value,
                    input ready);
    modport sink (input valid, req_type, coord_0, coord_1, coord_2, coord_3,
                  coef_output, coef_power, coef_dim, coef_value,
                  output ready);
endinterface

### rtl/spe_res_if.sv
// ----------------------------------------------------------------------------
// spe_res_if
// Result channel: one sum per output channel in use.
// ----------------------------------------------------------------------------
interface spe_res_if;
    import spe_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CHAN_W-1:0]         channel;
    logic signed [VALUE_W-1:0] value;
    logic                      last;

    modport source (output valid, channel, value, last, input ready);
    modport sink (input valid, channel, value, last, output ready);
endinterface

### rtl/spe_cfg_if.sv
// ----------------------------------------------------------------------------
// spe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface spe_cfg_if;
    import spe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/spe_ram.sv
// ----------------------------------------------------------------------------
// spe_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module spe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

### rtl/spe_mul.sv
// ----------------------------------------------------------------------------
// spe_mul
// Shared signed 16x16 multiplier with registered product.
// ----------------------------------------------------------------------------
module spe_mul (
    input  logic                              clk,
    input  logic                              load,
    input  logic signed [spe_pkg::DATA_W-1:0] a,
    input  logic signed [spe_pkg::DATA_W-1:0] b,
    output logic signed [spe_pkg::PROD_W-1:0] prod_reg
);
    import spe_pkg::*;

    // product register, updated only when the sequencer issues a multiply
    always_ff @(posedge clk)
    begin
        if (load)
            prod_reg <= PROD_W'(a) * PROD_W'(b);
    end
endmodule

### rtl/separable_polynomial_evaluator.sv
// ----------------------------------------------------------------------------
// separable_polynomial_evaluator
// Sums coefficient times coordinate power over dimensions and powers for
// each output channel, using one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  role
//  req      in   evaluate a point or write one coefficient
//  res      out  one saturated sum per channel, last on the final channel
//  cfg      in   register writes: degree, dims, outputs in use
//
//  a coefficient write goes straight into the table; an evaluate runs each
//  term through the single multiplier, power then coefficient, where the
//  first power is the coordinate itself and needs only the coefficient multiply.
//  req.ready is high only while idle; a result waits in the output
//  register, and the sequencer stalls before each new result until it frees.
//  rst_n resets the sequencer and the registers; coefficients are not cleared.
// ----------------------------------------------------------------------------
module separable_polynomial_evaluator #(
    parameter int MAX_DIMS    = spe_pkg::DEF_MAX_DIMS,
    parameter int MAX_DEGREE  = spe_pkg::DEF_MAX_DEGREE,
    parameter int MAX_OUTPUTS = spe_pkg::DEF_MAX_OUTPUTS
) (
    input  logic      clk,
    input  logic      rst_n,
    spe_req_if.sink   req,
    spe_res_if.source res,
    spe_cfg_if.sink   cfg
);
    import spe_pkg::*;

    localparam int DEPTH = MAX_OUTPUTS * MAX_DEGREE * MAX_DIMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CFG_W-1:0] DEG_HI  = CFG_W'((MAX_DEGREE > 7) ? 7 : MAX_DEGREE);
    localparam logic [CFG_W-1:0] DIMS_HI =
        CFG_W'((MAX_DIMS > COORD_FIELDS) ? COORD_FIELDS : MAX_DIMS);
    localparam logic [CFG_W-1:0] OUTS_HI = CFG_W'((MAX_OUTPUTS > 7) ? 7 : MAX_OUTPUTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_POW,
        S_PSAT,
        S_CMUL,
        S_ACC,
        S_OUT
    } state_t;

    state_t                    state_reg, state_next;
    logic [CFG_W-1:0]          cfg_degree_reg, cfg_degree_next;
    logic [CFG_W-1:0]          cfg_dims_reg, cfg_dims_next;
    logic [CFG_W-1:0]          cfg_outs_reg, cfg_outs_next;
    logic [CFG_W-1:0]          deg_reg, deg_next;
    logic [CFG_W-1:0]          dims_reg, dims_next;
    logic [CFG_W-1:0]          outs_reg, outs_next;
    logic [CFG_W-1:0]          o_reg, o_next;
    logic [CFG_W-1:0]          p_reg, p_next;
    logic [COORD_IDX_W-1:0]    k_reg, k_next;
    logic signed [DATA_W-1:0]  coord_reg [COORD_FIELDS];
    logic signed [DATA_W-1:0]  coord_next [COORD_FIELDS];
    logic signed [DATA_W-1:0]  pw_reg, pw_next;
    logic signed [VALUE_W-1:0] acc_reg, acc_next;
    logic                      res_valid_reg, res_valid_next;
    logic [CHAN_W-1:0]         res_chan_reg, res_chan_next;
    logic signed [VALUE_W-1:0] res_value_reg, res_value_next;
    logic                      res_last_reg, res_last_next;

    logic                      req_fire;
    logic                      cfg_fire;
    logic                      wr_ok;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [AW-1:0]             ram_raddr;
    logic [DATA_W-1:0]         ram_rdata;
    logic                      mul_load;
    logic signed [DATA_W-1:0]  mul_a;
    logic signed [DATA_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic                      slot_free;

    // handshakes
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;

    // coefficient write address and range check
    assign wr_ok = (32'(req.coef_output) < MAX_OUTPUTS) &&
                   (32'(req.coef_power) < MAX_DEGREE) &&
                   (32'(req.coef_dim) < MAX_DIMS);
    assign ram_we    = req_fire && (req.req_type == REQ_WRITE) && wr_ok;
    assign ram_waddr = AW'((32'(req.coef_output) * MAX_DEGREE + 32'(req.coef_power))
                           * MAX_DIMS + 32'(req.coef_dim));

    // read address follows the term counters
    assign ram_raddr = AW'((32'(o_reg) * MAX_DEGREE + 32'(p_reg)) * MAX_DIMS
                           + 32'(k_reg));

    spe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.coef_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared multiplier: power step or coefficient product
    assign mul_load = (state_reg == S_POW) || (state_reg == S_CMUL);
    assign mul_a    = (state_reg == S_CMUL) ? $signed(ram_rdata) : pw_reg;
    assign mul_b    = (state_reg == S_CMUL) ? pw_reg : coord_reg[k_reg];

    spe_mul u_mul (
        .clk      (clk),
        .load     (mul_load),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    // result outputs
    assign res.valid   = res_valid_reg;
    assign res.channel = res_chan_reg;
    assign res.value   = res_value_reg;
    assign res.last    = res_last_reg;
    assign slot_free   = !res_valid_reg || res.ready;

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        cfg_degree_next = cfg_degree_reg;
        cfg_dims_next   = cfg_dims_reg;
        cfg_outs_next   = cfg_outs_reg;
        deg_next        = deg_reg;
        dims_next       = dims_reg;
        outs_next       = outs_reg;
        o_next          = o_reg;
        p_next          = p_reg;
        k_next          = k_reg;
        coord_next      = coord_reg;
        pw_next         = pw_reg;
        acc_next        = acc_reg;
        res_valid_next  = res_valid_reg;
        res_chan_next   = res_chan_reg;
        res_value_next  = res_value_reg;
        res_last_next   = res_last_reg;

        // result register drains independently
        if (res_valid_reg && res.ready)
            res_valid_next = 1'b0;

        // configuration writes
        if (cfg_fire)
        begin
            unique case (cfg.index)
                CFG_DEGREE:  cfg_degree_next = cfg.data;
                CFG_DIMS:    cfg_dims_next   = cfg.data;
                CFG_OUTPUTS: cfg_outs_next   = cfg.data;
                default:     ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.req_type == REQ_EVAL))
                begin
                    coord_next[0] = req.coord_0;
                    coord_next[1] = req.coord_1;
                    coord_next[2] = req.coord_2;
                    coord_next[3] = req.coord_3;
                    deg_next      = limit_cfg(cfg_degree_reg, DEG_HI);
                    dims_next     = limit_cfg(cfg_dims_reg, DIMS_HI);
                    outs_next     = limit_cfg(cfg_outs_reg, OUTS_HI);
                    o_next        = '0;
                    p_next        = '0;
                    k_next        = '0;
                    acc_next      = '0;
                    state_next    = S_FETCH;
                end
            end
            // first power is the coordinate itself; coefficient read in flight
            S_FETCH:
            begin
                pw_next    = coord_reg[k_reg];
                state_next = S_CMUL;
            end
            S_POW:
            begin
                state_next = S_PSAT;
            end
            S_PSAT:
            begin
                pw_next    = pow_sat(prod);
                state_next = S_CMUL;
            end
            S_CMUL:
            begin
                state_next = S_ACC;
            end
            // accumulate, then step power and dimension; the channel steps in S_OUT
            S_ACC:
            begin
                acc_next = acc_add(acc_reg, prod);
                if (p_reg + CFG_W'(1) < deg_reg)
                begin
                    p_next     = p_reg + CFG_W'(1);
                    state_next = S_POW;
                end
                else
                begin
                    p_next = '0;
                    if (CFG_W'(k_reg) + CFG_W'(1) < dims_reg)
                    begin
                        k_next     = k_reg + COORD_IDX_W'(1);
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    res_chan_next  = o_reg[CHAN_W-1:0];
                    res_value_next = acc_reg;
                    res_last_next  = (o_reg + CFG_W'(1) == outs_reg);
                    acc_next       = '0;
                    k_next         = '0;
                    if (o_reg + CFG_W'(1) < outs_reg)
                    begin
                        o_next     = o_reg + CFG_W'(1);
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cfg_degree_reg <= CFG_W'(4);
            cfg_dims_reg   <= CFG_W'(4);
            cfg_outs_reg   <= CFG_W'(4);
            deg_reg        <= CFG_W'(1);
            dims_reg       <= CFG_W'(1);
            outs_reg       <= CFG_W'(1);
            o_reg          <= '0;
            p_reg          <= '0;
            k_reg          <= '0;
            for (int i = 0; i < COORD_FIELDS; i++)
                coord_reg[i] <= '0;
            pw_reg         <= '0;
            acc_reg        <= '0;
            res_valid_reg  <= 1'b0;
            res_chan_reg   <= '0;
            res_value_reg  <= '0;
            res_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cfg_degree_reg <= cfg_degree_next;
            cfg_dims_reg   <= cfg_dims_next;
            cfg_outs_reg   <= cfg_outs_next;
            deg_reg        <= deg_next;
            dims_reg       <= dims_next;
            outs_reg       <= outs_next;
            o_reg          <= o_next;
            p_reg          <= p_next;
            k_reg          <= k_next;
            coord_reg      <= coord_next;
            pw_reg         <= pw_next;
            acc_reg        <= acc_next;
            res_valid_reg  <= res_valid_next;
            res_chan_reg   <= res_chan_next;
            res_value_reg  <= res_value_next;
            res_last_reg   <= res_last_next;
        end
    end
endmodule

### test/tb_separable_polynomial_evaluator.sv
// ----------------------------------------------------------------------------
// tb_separable_polynomial_evaluator
// Self-checking bench for the separable polynomial evaluator. A scoreboard
// keeps its own coefficient table and register copies, predicts every
// channel sum of each accepted point and compares the results in order.
// Directed points hit the coordinate and coefficient extremes. Random phases
// then run under several register settings with gaps on the request side
// and stalls on the result side.
// ----------------------------------------------------------------------------
module tb_separable_polynomial_evaluator;
    timeunit 1ns;
    timeprecision 1ps;

    import spe_pkg::*;

    // sizes of the default build
    localparam int unsigned MAX_OUT     = DEF_MAX_OUTPUTS;
    localparam int unsigned MAX_DEG     = DEF_MAX_DEGREE;
    localparam int unsigned MAX_DIM     = DEF_MAX_DIMS;
    localparam int unsigned DIM_TOP     = (MAX_DIM < COORD_FIELDS) ? MAX_DIM : COORD_FIELDS;
    localparam int unsigned STORE_DEPTH = MAX_OUT * MAX_DEG * MAX_DIM;

    // longest evaluate at the largest sizes
    localparam int unsigned EVAL_CYCLES = 1 + MAX_OUT * (MAX_DIM * (4 * MAX_DEG - 1) + 1);
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    localparam longint RESULT_HI = 1048575;
    localparam longint RESULT_LO = -1048576;
    localparam longint POWER_HI  = 32767;
    localparam longint POWER_LO  = -32768;

    // register index past the list, written to check that it is ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic                     req_type;
        logic signed [DATA_W-1:0] coord [COORD_FIELDS];
        logic [SEL_W-1:0]         coef_output;
        logic [SEL_W-1:0]         coef_power;
        logic [SEL_W-1:0]         coef_dim;
        logic signed [DATA_W-1:0] coef_value;
    } poly_req_t;

    typedef struct {
        logic [CHAN_W-1:0]         channel;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } poly_sum_t;

    // ------------------------------------------------------------------------
    // scoreboard: coefficient table, register copies and the sums still due
    // ------------------------------------------------------------------------
    class poly_scoreboard;
        logic signed [DATA_W-1:0] coef_table [STORE_DEPTH];
        bit [STORE_DEPTH-1:0]     coef_known;
        logic [CFG_W-1:0]         degree_reg;
        logic [CFG_W-1:0]         dims_reg;
        logic [CFG_W-1:0]         outputs_reg;
        poly_sum_t                sums_due [$];
        int unsigned              mismatches;
        int unsigned              sums_checked;

        function new();
            coef_known   = '0;
            degree_reg   = CFG_W'(4);
            dims_reg     = CFG_W'(4);
            outputs_reg  = CFG_W'(4);
            mismatches   = 0;
            sums_checked = 0;
        endfunction

        // zero counts as one, anything past the top as the top
        function int unsigned clip(input logic [CFG_W-1:0] v, input int unsigned top);
            if (v == '0)
                return 1;
            return (int'(v) > top) ? top : int'(v);
        endfunction

        function int unsigned coef_slot(input int unsigned o, input int unsigned p,
                                        input int unsigned k);
            return (o * MAX_DEG + p) * MAX_DIM + k;
        endfunction

        function longint saturate(input longint v, input longint lo, input longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] val);
            case (idx)
                CFG_DEGREE:  degree_reg  = val;
                CFG_DIMS:    dims_reg    = val;
                CFG_OUTPUTS: outputs_reg = val;
                default:     ;
            endcase
        endfunction

        // first table entry that an evaluate would read before it was written
        function bit missing_coef(output int unsigned slot);
            int unsigned o, p, k;
            slot = 0;
            for (o = 0; o < clip(outputs_reg, MAX_OUT); o++)
                for (p = 0; p < clip(degree_reg, MAX_DEG); p++)
                    for (k = 0; k < clip(dims_reg, DIM_TOP); k++)
                        if (!coef_known[coef_slot(o, p, k)]) begin
                            slot = coef_slot(o, p, k);
                            return 1'b1;
                        end
            return 1'b0;
        endfunction

        // store a coefficient, or work out the channel sums of a point
        function void note_request(input poly_req_t r);
            int unsigned slot, outs, dims, deg, o, k, p;
            longint      acc, pw, x, term;
            poly_sum_t   s;
            if (r.req_type == REQ_WRITE) begin
                slot             = coef_slot(r.coef_output, r.coef_power, r.coef_dim);
                coef_table[slot] = r.coef_value;
                coef_known[slot] = 1'b1;
                return;
            end
            deg  = clip(degree_reg, MAX_DEG);
            dims = clip(dims_reg, DIM_TOP);
            outs = clip(outputs_reg, MAX_OUT);
            for (o = 0; o < outs; o++) begin
                acc = 0;
                for (k = 0; k < dims; k++) begin
                    x  = r.coord[k];
                    pw = x;
                    for (p = 0; p < deg; p++) begin
                        // next power floored to Q2.14 and held to 16 bits
                        if (p > 0)
                            pw = saturate((pw * x) >>> 14, POWER_LO, POWER_HI);
                        term = (longint'(coef_table[coef_slot(o, p, k)]) * pw) >>> 15;
                        acc  = saturate(acc + term, RESULT_LO, RESULT_HI);
                    end
                end
                s.channel = CHAN_W'(o);
                s.value   = VALUE_W'(acc);
                s.last    = (o + 1 == outs);
                sums_due  = {sums_due, s};
            end
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(input logic [CHAN_W-1:0] channel,
                          input logic signed [VALUE_W-1:0] value, input logic last);
            poly_sum_t s;
            if (sums_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result channel %0d value %0d",
                                          channel, value));
                return;
            end
            s = sums_due.pop_front();
            sums_checked++;
            if (channel !== s.channel)
                report_mismatch($sformatf("channel %0d, predicted %0d", channel, s.channel));
            if (value !== s.value)
                report_mismatch($sformatf("channel %0d value %0d, predicted %0d",
                                          s.channel, value, s.value));
            if (last !== s.last)
                report_mismatch($sformatf("channel %0d last %0b, predicted %0b",
                                          s.channel, last, s.last));
        endtask

        task check_drained();
            if (sums_due.size() != 0)
                report_mismatch($sformatf("%0d predicted sums never arrived",
                                          sums_due.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #1 clk = ~clk;

    spe_req_if req_bus ();
    spe_res_if res_bus ();
    spe_cfg_if cfg_bus ();

    separable_polynomial_evaluator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    poly_scoreboard board;
    bit             sink_steady;
    int unsigned    cycles = 0;
    int unsigned    n_eval;
    int unsigned    n_write;
    int unsigned    n_settings;

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("separable_polynomial_evaluator verification failed");
            $finish;
        end
    end

    // result side stalls: mostly short, a few long
    initial begin
        int unsigned hold, roll;
        hold          = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
                res_bus.ready <= 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (sink_steady || roll < 70) begin
                    res_bus.ready <= 1'b1;
                end else begin
                    res_bus.ready <= 1'b0;
                    hold = (roll < 96) ? $urandom_range(0, 3) : $urandom_range(15, 40);
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && res_bus.valid && res_bus.ready)
            board.check_result(res_bus.channel, res_bus.value, res_bus.last);
    end

    // ------------------------------------------------------------------------
    // request building
    // ------------------------------------------------------------------------
    function automatic logic signed [DATA_W-1:0] random_coord();
        int roll, v;
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
            v = int'($urandom_range(0, 32768)) - 16384;
            return DATA_W'(v);
        end
        if (roll == 6) begin
            case ($urandom_range(0, 4))
                0:       return 16'sd16384;
                1:       return -16'sd16384;
                2:       return 16'sd0;
                3:       return -16'sd1;
                default: return 16'sd1;
            endcase
        end
        return DATA_W'($urandom);
    endfunction

    function automatic logic signed [DATA_W-1:0] random_coef();
        if ($urandom_range(0, 9) < 8)
            return DATA_W'($urandom);
        case ($urandom_range(0, 4))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    function automatic poly_req_t random_request(input int unsigned write_pct);
        poly_req_t   r;
        int unsigned slot, k;
        for (k = 0; k < COORD_FIELDS; k++)
            r.coord[k] = random_coord();
        r.coef_output = SEL_W'($urandom);
        r.coef_power  = SEL_W'($urandom);
        r.coef_dim    = SEL_W'($urandom);
        r.coef_value  = random_coef();
        r.req_type    = ($urandom_range(0, 99) < write_pct) ? REQ_WRITE : REQ_EVAL;
        // a point is only sent once every coefficient it reads is known
        if (r.req_type == REQ_EVAL && board.missing_coef(slot)) begin
            r.req_type    = REQ_WRITE;
            r.coef_output = SEL_W'(slot / (MAX_DEG * MAX_DIM));
            r.coef_power  = SEL_W'((slot / MAX_DIM) % MAX_DEG);
            r.coef_dim    = SEL_W'(slot % MAX_DIM);
        end
        return r;
    endfunction

    function automatic poly_req_t point_req(input int c0, input int c1, input int c2,
                                            input int c3);
        poly_req_t r;
        r            = random_request(0);
        r.req_type   = REQ_EVAL;
        r.coord[0]   = DATA_W'(c0);
        r.coord[1]   = DATA_W'(c1);
        r.coord[2]   = DATA_W'(c2);
        r.coord[3]   = DATA_W'(c3);
        return r;
    endfunction

    function automatic poly_req_t coef_req(input int unsigned o, input int unsigned p,
                                           input int unsigned k, input int v);
        poly_req_t r;
        r             = random_request(100);
        r.req_type    = REQ_WRITE;
        r.coef_output = SEL_W'(o);
        r.coef_power  = SEL_W'(p);
        r.coef_dim    = SEL_W'(k);
        r.coef_value  = DATA_W'(v);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driving tasks
    // ------------------------------------------------------------------------
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        board.apply_register(idx, val);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] deg, input logic [CFG_W-1:0] dims,
                                 input logic [CFG_W-1:0] outs);
        set_register(CFG_DEGREE, deg);
        set_register(CFG_DIMS, dims);
        set_register(CFG_OUTPUTS, outs);
        n_settings++;
    endtask

    // idle gap before a request; valid stays up when there is none
    task automatic request_gap(input bit steady);
        int unsigned roll, n;
        roll = $urandom_range(0, 99);
        if (steady || roll < 65)
            n = 0;
        else if (roll < 95)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(15, 50);
        if (n > 0) begin
            req_bus.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_request(input poly_req_t r, input bit steady);
        request_gap(steady);
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= r.req_type;
        req_bus.coord_0     <= r.coord[0];
        req_bus.coord_1     <= r.coord[1];
        req_bus.coord_2     <= r.coord[2];
        req_bus.coord_3     <= r.coord[3];
        req_bus.coef_output <= r.coef_output;
        req_bus.coef_power  <= r.coef_power;
        req_bus.coef_dim    <= r.coef_dim;
        req_bus.coef_value  <= r.coef_value;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        board.note_request(r);
        if (r.req_type == REQ_WRITE)
            n_write++;
        else
            n_eval++;
    endtask

    task automatic wait_sums_drained();
        req_bus.valid <= 1'b0;
        while (board.sums_due.size() != 0)
            @(posedge clk);
    endtask

    // block idle: all sums in and any trailing work finished
    task automatic settle();
        wait_sums_drained();
        repeat (EVAL_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned ph, i, phase_len;
        bit          src_steady;
        logic [CFG_W-1:0] deg, dims, outs;

        board       = new();
        sink_steady = 1'b0;
        n_eval      = 0;
        n_write     = 0;
        n_settings  = 0;

        rst_n               = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.req_type    = REQ_EVAL;
        req_bus.coord_0     = '0;
        req_bus.coord_1     = '0;
        req_bus.coord_2     = '0;
        req_bus.coord_3     = '0;
        req_bus.coef_output = '0;
        req_bus.coef_power  = '0;
        req_bus.coef_dim    = '0;
        req_bus.coef_value  = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_DEGREE;
        cfg_bus.data        = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first power only, all four coordinates, one channel; zero and
        // over-range register values
        apply_setting(CFG_W'(0), CFG_W'(7), CFG_W'(1));
        send_request(coef_req(0, 0, 0, 32767), 1'b1);
        send_request(coef_req(0, 0, 1, -32768), 1'b1);
        send_request(coef_req(0, 0, 2, -1), 1'b1);
        send_request(coef_req(0, 0, 3, 1), 1'b1);
        send_request(point_req(16384, 16384, 16384, 16384), 1'b1);
        send_request(point_req(-16384, -16384, -16384, -16384), 1'b1);
        send_request(point_req(32767, 32767, 32767, 32767), 1'b1);
        send_request(point_req(-32768, -32768, -32768, -32768), 1'b1);
        send_request(point_req(0, -1, 1, -2), 1'b1);
        settle();

        // all powers of one coordinate; powers past the Q2.14 range saturate
        apply_setting(CFG_W'(7), CFG_W'(0), CFG_W'(0));
        set_register(CFG_UNUSED, CFG_W'(7));
        send_request(coef_req(0, 1, 0, 32767), 1'b1);
        send_request(coef_req(0, 2, 0, -32768), 1'b1);
        send_request(coef_req(0, 3, 0, 12345), 1'b1);
        send_request(point_req(32767, 0, 0, 0), 1'b1);
        send_request(point_req(-32768, 0, 0, 0), 1'b1);
        send_request(point_req(-16384, 0, 0, 0), 1'b1);
        send_request(point_req(16384, 0, 0, 0), 1'b1);
        send_request(point_req(-1, 0, 0, 0), 1'b1);
        settle();

        // random phases, each under its own register setting
        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin deg = CFG_W'(4); dims = CFG_W'(4); outs = CFG_W'(4); end
                1: begin deg = CFG_W'(0); dims = CFG_W'(0); outs = CFG_W'(0); end
                2: begin deg = CFG_W'(7); dims = CFG_W'(7); outs = CFG_W'(7); end
                3: begin deg = CFG_W'(2); dims = CFG_W'(3); outs = CFG_W'(1); end
                4: begin deg = CFG_W'(1); dims = CFG_W'(4); outs = CFG_W'(3); end
                5: begin deg = CFG_W'(3); dims = CFG_W'(1); outs = CFG_W'(2); end
                default: begin
                    deg  = CFG_W'($urandom_range(0, 7));
                    dims = CFG_W'($urandom_range(0, 7));
                    outs = CFG_W'($urandom_range(0, 7));
                end
            endcase
            apply_setting(deg, dims, outs);
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            phase_len   = (ph == 0) ? 120 : 50;
            for (i = 0; i < phase_len; i++) begin
                // in phase 2 the sender once holds off until every pending sum is in
                if (ph == 2 && i == 25)
                    wait_sums_drained();
                send_request(random_request(25), src_steady);
            end
            settle();
        end

        board.check_drained();
        $display("covered %0d points and %0d coefficient writes under %0d register settings",
                 n_eval, n_write, n_settings);
        $display("%0d channel sums compared, %0d mismatches",
                 board.sums_checked, board.mismatches);
        if (board.mismatches == 0)
            $display("separable_polynomial_evaluator verification clean");
        else
            $display("separable_polynomial_evaluator verification failed");
        $finish;
    end

endmodule
